### src/thermistor_fault_monitor_macros.svh
// ----------------------------------------------------------------------------
// Thermistor fault monitor assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_FAULT_MONITOR_MACROS_SVH
`define THERMISTOR_FAULT_MONITOR_MACROS_SVH

// Generic property check on clk_i with async reset rst_ni.
`define TFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent implies consequent on the following cycle.
`define TFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  `TFM_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### src/tfm_pkg.sv
// ----------------------------------------------------------------------------
// Thermistor fault monitor package
// Widths, reset values, register indexes, fault codes and shared types.
// ----------------------------------------------------------------------------
package tfm_pkg;

  localparam int SampleW      = 10;
  localparam int NumSamples   = 10;
  localparam int NumLanes     = NumSamples / 2;
  localparam int LaneSumW     = SampleW + 1;
  localparam int TotalSumW    = SampleW + $clog2(NumSamples);
  localparam int TrimShift    = 3;
  localparam int ConfirmCount = 3;
  localparam int CfgIdxW      = 2;
  localparam int StatusW      = 2;

  typedef logic [SampleW-1:0]      sample_t;
  typedef logic [ConfirmCount-1:0] hist_t;
  typedef logic [StatusW-1:0]      status_t;

  localparam sample_t OpenLimitRst    = sample_t'(854);
  localparam sample_t HotLimitRst     = sample_t'(150);
  localparam sample_t RestoreLimitRst = sample_t'(280);

  localparam logic [CfgIdxW-1:0] RegOpenLimit    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHotLimit     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRestoreLimit = 2'd2;

  localparam status_t FaultNormal = 2'd0;
  localparam status_t FaultOpen   = 2'd1;
  localparam status_t FaultHot    = 2'd2;

  typedef enum logic [2:0] {
    StNormal = 3'b001,
    StOpen   = 3'b010,
    StHot    = 3'b100
  } fault_state_e;

  typedef struct packed {
    sample_t               lo;
    sample_t               hi;
    logic [LaneSumW-1:0]   sum;
  } lane_t;

  typedef struct packed {
    sample_t open_limit;
    sample_t hot_limit;
    sample_t restore_limit;
  } limits_t;

endpackage

### src/tfm_lane.sv
// ----------------------------------------------------------------------------
// Thermistor fault monitor lane
// Registered min, max and sum of one pair of readings.
// ----------------------------------------------------------------------------
module tfm_lane (
  input  logic            clk_i,
  input  logic            en_i,
  input  tfm_pkg::sample_t a_i,
  input  tfm_pkg::sample_t b_i,
  output tfm_pkg::lane_t  lane_o
);

  tfm_pkg::lane_t lane_d, lane_q;

  always_comb begin
    lane_d.lo  = (a_i < b_i) ? a_i : b_i;
    lane_d.hi  = (a_i < b_i) ? b_i : a_i;
    lane_d.sum = tfm_pkg::LaneSumW'(a_i) + tfm_pkg::LaneSumW'(b_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

### src/tfm_merge.sv
// ----------------------------------------------------------------------------
// Thermistor fault monitor merge
// Combines lane results into the trimmed mean and registers it.
// ----------------------------------------------------------------------------
module tfm_merge (
  input  logic             clk_i,
  input  logic             en_i,
  input  tfm_pkg::lane_t   lanes_i [tfm_pkg::NumLanes],
  output tfm_pkg::sample_t avg_o
);

  tfm_pkg::sample_t avg_d, avg_q;

  always_comb begin
    tfm_pkg::sample_t               min_v;
    tfm_pkg::sample_t               max_v;
    logic [tfm_pkg::TotalSumW-1:0]  sum_v;
    logic [tfm_pkg::TotalSumW-1:0]  trim_v;
    min_v = lanes_i[0].lo;
    max_v = lanes_i[0].hi;
    sum_v = tfm_pkg::TotalSumW'(lanes_i[0].sum);
    for (int i = 1; i < tfm_pkg::NumLanes; i++) begin
      if (lanes_i[i].lo < min_v) min_v = lanes_i[i].lo;
      if (lanes_i[i].hi > max_v) max_v = lanes_i[i].hi;
      sum_v = sum_v + tfm_pkg::TotalSumW'(lanes_i[i].sum);
    end
    trim_v = sum_v - tfm_pkg::TotalSumW'(min_v) - tfm_pkg::TotalSumW'(max_v);
    avg_d  = tfm_pkg::SampleW'(trim_v >> tfm_pkg::TrimShift);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      avg_q <= avg_d;
    end
  end

  assign avg_o = avg_q;

endmodule

### src/tfm_fsm.sv
// ----------------------------------------------------------------------------
// Thermistor fault monitor state machine
// Comparison histories, fault state and registered result fields.
// ----------------------------------------------------------------------------
`include "thermistor_fault_monitor_macros.svh"

module tfm_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  tfm_pkg::sample_t  avg_i,
  input  tfm_pkg::limits_t  limits_i,
  output tfm_pkg::status_t  fault_status_o,
  output logic              status_changed_o,
  output logic              force_power_off_o,
  output tfm_pkg::sample_t  filtered_reading_o
);

  tfm_pkg::hist_t        open_d, open_q, hot_d, hot_q, rest_d, rest_q;
  tfm_pkg::fault_state_e state_d, state_q;
  tfm_pkg::status_t      status_d, status_q;
  logic                  changed_d, changed_q, poff_d, poff_q;
  tfm_pkg::sample_t      avg_q;

  always_comb begin
    open_d = (open_q << 1) | tfm_pkg::hist_t'(avg_i > limits_i.open_limit);
    hot_d  = (hot_q  << 1) | tfm_pkg::hist_t'(avg_i < limits_i.hot_limit);
    rest_d = (rest_q << 1) | tfm_pkg::hist_t'(avg_i > limits_i.restore_limit);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tfm_pkg::StNormal: begin
        if (&open_d) state_d = tfm_pkg::StOpen;
        else if (&hot_d) state_d = tfm_pkg::StHot;
      end
      tfm_pkg::StOpen: begin
        if (~|open_d) state_d = (&hot_d) ? tfm_pkg::StHot : tfm_pkg::StNormal;
      end
      tfm_pkg::StHot: begin
        if (~|hot_d) begin
          if (&open_d) state_d = tfm_pkg::StOpen;
          else if (&rest_d) state_d = tfm_pkg::StNormal;
        end
      end
      default: state_d = tfm_pkg::StNormal;
    endcase
  end

  always_comb begin
    unique case (state_d)
      tfm_pkg::StOpen: status_d = tfm_pkg::FaultOpen;
      tfm_pkg::StHot:  status_d = tfm_pkg::FaultHot;
      default:         status_d = tfm_pkg::FaultNormal;
    endcase
    changed_d = (state_d != state_q);
    poff_d    = (state_d == tfm_pkg::StHot) && (state_q != tfm_pkg::StHot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= '0;
      hot_q   <= '0;
      rest_q  <= '0;
      state_q <= tfm_pkg::StNormal;
    end else if (en_i) begin
      open_q  <= open_d;
      hot_q   <= hot_d;
      rest_q  <= rest_d;
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      status_q  <= status_d;
      changed_q <= changed_d;
      poff_q    <= poff_d;
      avg_q     <= avg_i;
    end
  end

  assign fault_status_o     = status_q;
  assign status_changed_o   = changed_q;
  assign force_power_off_o  = poff_q;
  assign filtered_reading_o = avg_q;

  `TFM_ASSERT_NEXT(a_hold_when_idle, !en_i,
    $stable(state_q) && $stable(open_q) && $stable(hot_q), "state moved without transaction")
  `TFM_ASSERT_NEXT(a_poff_on_entry, en_i && state_d == tfm_pkg::StHot && state_q != tfm_pkg::StHot,
    poff_q && changed_q && status_q == tfm_pkg::FaultHot, "missed power-off on hot entry")
  `TFM_ASSERT_NEXT(a_hot_sticky, en_i && state_q == tfm_pkg::StHot && hot_d != '0,
    state_q == tfm_pkg::StHot, "left over temperature while hot history active")
  `TFM_ASSERT_NEXT(a_open_from_normal, en_i && state_q == tfm_pkg::StNormal && (&open_d),
    state_q == tfm_pkg::StOpen, "full open history did not raise sensor open")

endmodule

### src/thermistor_fault_monitor.sv
// ----------------------------------------------------------------------------
// Thermistor fault monitor
// Trimmed mean of ten readings with debounced open / hot / restore detection.
// ----------------------------------------------------------------------------
// Takes one transaction of ten readings per clock unless stalled and returns
// one result per transaction, through five pair lanes (min, max, sum), a merge
// stage forming the trimmed mean, and the state-machine/output register.
// Throughput is one transaction per cycle; a stall on the output holds the
// whole pipeline and is passed back to the input in the same cycle.
// Limit registers may only be written while no transaction is in flight.
module thermistor_fault_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tfm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tfm_pkg::SampleW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tfm_pkg::SampleW-1:0]   sample_0_i,
  input  logic [tfm_pkg::SampleW-1:0]   sample_1_i,
  input  logic [tfm_pkg::SampleW-1:0]   sample_2_i,
  input  logic [tfm_pkg::SampleW-1:0]   sample_3_i,
  input  logic [tfm_pkg::SampleW-1:0]   sample_4_i,
  input  logic [tfm_pkg::SampleW-1:0]   sample_5_i,
  input  logic [tfm_pkg::SampleW-1:0]   sample_6_i,
  input  logic [tfm_pkg::SampleW-1:0]   sample_7_i,
  input  logic [tfm_pkg::SampleW-1:0]   sample_8_i,
  input  logic [tfm_pkg::SampleW-1:0]   sample_9_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tfm_pkg::StatusW-1:0]   fault_status_o,
  output logic                          status_changed_o,
  output logic                          force_power_off_o,
  output logic [tfm_pkg::SampleW-1:0]   filtered_reading_o
);

  tfm_pkg::sample_t samples [tfm_pkg::NumSamples];
  tfm_pkg::lane_t   lanes   [tfm_pkg::NumLanes];
  tfm_pkg::sample_t avg;
  tfm_pkg::limits_t limits_d, limits_q;
  logic             adv;
  logic             s1_valid_q, s2_valid_q, out_valid_q;

  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;
  assign samples[6] = sample_6_i;
  assign samples[7] = sample_7_i;
  assign samples[8] = sample_8_i;
  assign samples[9] = sample_9_i;

  always_comb begin
    limits_d = limits_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tfm_pkg::RegOpenLimit:    limits_d.open_limit    = cfg_wdata_i;
        tfm_pkg::RegHotLimit:     limits_d.hot_limit     = cfg_wdata_i;
        tfm_pkg::RegRestoreLimit: limits_d.restore_limit = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.open_limit    <= tfm_pkg::OpenLimitRst;
      limits_q.hot_limit     <= tfm_pkg::HotLimitRst;
      limits_q.restore_limit <= tfm_pkg::RestoreLimitRst;
    end else begin
      limits_q <= limits_d;
    end
  end

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  for (genvar g = 0; g < tfm_pkg::NumLanes; g++) begin : g_lane
    tfm_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .a_i    (samples[2*g]),
      .b_i    (samples[2*g+1]),
      .lane_o (lanes[g])
    );
  end

  tfm_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (adv),
    .lanes_i (lanes),
    .avg_o   (avg)
  );

  tfm_fsm u_fsm (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (adv && s2_valid_q),
    .avg_i              (avg),
    .limits_i           (limits_q),
    .fault_status_o     (fault_status_o),
    .status_changed_o   (status_changed_o),
    .force_power_off_o  (force_power_off_o),
    .filtered_reading_o (filtered_reading_o)
  );

  assign out_valid_o = out_valid_q;

endmodule
